// File: hdl/mmm_pkg.sv
// ----------------------------------------------------------------------------
// mmm_pkg: shared types and constants for the 256-bit Montgomery multiplier
// Word sizes, register indexes, controller states and the datapath command struct.
// ----------------------------------------------------------------------------
package mmm_pkg;

    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 4;
    localparam int T_WORDS   = 2 * NUM_WORDS + 1;
    localparam int IDX_W     = 2;
    localparam int TIDX_W    = 4;
    localparam int PART_W    = 2;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;

    localparam logic [2:0] REG_MOD_W0  = 3'd0;
    localparam logic [2:0] REG_MOD_W1  = 3'd1;
    localparam logic [2:0] REG_MOD_W2  = 3'd2;
    localparam logic [2:0] REG_MOD_W3  = 3'd3;
    localparam logic [2:0] REG_NEG_INV = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MQ,
        ST_RED,
        ST_PROP,
        ST_SUB,
        ST_DONE
    } state_t;

    // Multiply-accumulate source select
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PROD,
        OP_MQ,
        OP_RED
    } op_t;

    typedef struct packed {
        logic              load;
        op_t               op;
        logic [IDX_W-1:0]  i;
        logic [IDX_W-1:0]  j;
        logic [PART_W-1:0] part;
        logic              mac_first;
        logic              mac_last;
        logic [TIDX_W-1:0] prop_k;
        logic              prop_en;
        logic              prop_first;
        logic              sub_en;
        logic              sub_first;
        logic [IDX_W-1:0]  sub_j;
        logic              sub_last;
    } dp_cmd_t;

endpackage

// File: hdl/mmm_ctrl.sv
// ----------------------------------------------------------------------------
// mmm_ctrl: sequencer for the Montgomery multiplier
// Steps the datapath through product, reduction, carry ripple and subtraction.
// ----------------------------------------------------------------------------
module mmm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             res_taken,
    output logic             busy,
    output logic             res_valid,
    output mmm_pkg::dp_cmd_t cmd
);

    mmm_pkg::state_t                    state_reg, state_next;
    logic [mmm_pkg::IDX_W-1:0]          i_reg, i_next;
    logic [mmm_pkg::IDX_W-1:0]          j_reg, j_next;
    logic [mmm_pkg::TIDX_W-1:0]         k_reg, k_next;
    logic [mmm_pkg::PART_W-1:0]         part_reg, part_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mmm_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            part_reg  <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            part_reg  <= part_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        part_next      = part_reg;
        cmd            = '0;
        cmd.op         = mmm_pkg::OP_NONE;
        cmd.i          = i_reg;
        cmd.j          = j_reg;
        cmd.part       = part_reg;
        cmd.sub_j      = j_reg;
        cmd.mac_first  = (j_reg == '0);
        cmd.mac_last   = (j_reg == '1);
        cmd.sub_first  = (j_reg == '0);
        cmd.sub_last   = (j_reg == '1);
        busy           = (state_reg != mmm_pkg::ST_IDLE);
        res_valid      = (state_reg == mmm_pkg::ST_DONE);
        unique case (state_reg)
            mmm_pkg::ST_IDLE: begin
                if (start) begin
                    cmd.load   = 1'b1;
                    i_next     = '0;
                    j_next     = '0;
                    part_next  = '0;
                    state_next = mmm_pkg::ST_MUL;
                end
            end
            mmm_pkg::ST_MUL: begin
                cmd.op    = mmm_pkg::OP_PROD;
                part_next = part_reg + 1'b1;
                if (part_reg == '1) begin
                    j_next = j_reg + 1'b1;
                    if (j_reg == '1) begin
                        i_next = i_reg + 1'b1;
                        if (i_reg == '1) begin
                            state_next = mmm_pkg::ST_MQ;
                        end
                    end
                end
            end
            mmm_pkg::ST_MQ: begin
                cmd.op    = mmm_pkg::OP_MQ;
                part_next = part_reg + 1'b1;
                if (part_reg == '1) begin
                    j_next     = '0;
                    state_next = mmm_pkg::ST_RED;
                end
            end
            mmm_pkg::ST_RED: begin
                cmd.op    = mmm_pkg::OP_RED;
                part_next = part_reg + 1'b1;
                if (part_reg == '1) begin
                    j_next = j_reg + 1'b1;
                    if (j_reg == '1) begin
                        // ripple the carry from word i+4 up to word 8
                        k_next     = {2'b01, i_reg};
                        state_next = mmm_pkg::ST_PROP;
                    end
                end
            end
            mmm_pkg::ST_PROP: begin
                cmd.prop_en    = 1'b1;
                cmd.prop_k     = k_reg;
                cmd.prop_first = (k_reg == {2'b01, i_reg});
                k_next         = k_reg + 1'b1;
                if (k_reg == 4'd8) begin
                    i_next = i_reg + 1'b1;
                    j_next = '0;
                    if (i_reg == '1) begin
                        state_next = mmm_pkg::ST_SUB;
                    end else begin
                        state_next = mmm_pkg::ST_MQ;
                    end
                end
            end
            mmm_pkg::ST_SUB: begin
                cmd.sub_en = 1'b1;
                j_next     = j_reg + 1'b1;
                if (j_reg == '1) begin
                    state_next = mmm_pkg::ST_DONE;
                end
            end
            mmm_pkg::ST_DONE: begin
                if (res_taken) begin
                    state_next = mmm_pkg::ST_IDLE;
                end
            end
            default: state_next = mmm_pkg::ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mmm_pkg::ST_DONE && !res_taken) |=> state_reg == mmm_pkg::ST_DONE)
        else $error("result dropped before taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == mmm_pkg::ST_IDLE)
        else $error("load outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mmm_pkg::ST_PROP |-> k_reg >= 4'd4 && k_reg <= 4'd8)
        else $error("carry ripple index out of range");

endmodule

// File: hdl/mmm_dp.sv
// ----------------------------------------------------------------------------
// mmm_dp: Montgomery multiplier datapath
// One shared 32x32 multiplier run four passes per 64x64 multiply-accumulate,
// the 9-word accumulator and subtractor.
// ----------------------------------------------------------------------------
module mmm_dp (
    input  logic                        aclk,
    input  mmm_pkg::dp_cmd_t            cmd,
    input  logic [mmm_pkg::WORD_W-1:0]  a_in [mmm_pkg::NUM_WORDS],
    input  logic [mmm_pkg::WORD_W-1:0]  b_in [mmm_pkg::NUM_WORDS],
    input  logic [mmm_pkg::WORD_W-1:0]  modulus [mmm_pkg::NUM_WORDS],
    input  logic [mmm_pkg::WORD_W-1:0]  neg_inv,
    output logic [mmm_pkg::WORD_W-1:0]  r_out [mmm_pkg::NUM_WORDS]
);

    localparam int W  = mmm_pkg::WORD_W;
    localparam int HW = W / 2;

    logic [W-1:0]   a_reg [mmm_pkg::NUM_WORDS];
    logic [W-1:0]   b_reg [mmm_pkg::NUM_WORDS];
    logic [W-1:0]   t_reg [mmm_pkg::T_WORDS];
    logic [W-1:0]   carry_reg;
    logic [W-1:0]   m_reg;
    logic           ge_reg;
    logic           borrow_reg;
    logic [W-1:0]   res_reg [mmm_pkg::NUM_WORDS];
    logic [2*W-1:0] macc_reg;

    logic [W-1:0]   x, y, acc_in, cin;
    logic [HW-1:0]  mul_x, mul_y;
    logic [W-1:0]   pp;
    logic [2*W-1:0] pp_sh;
    logic [2*W-1:0] base;
    logic [2*W-1:0] macc_sum;
    logic           mac_done;
    logic [mmm_pkg::TIDX_W-1:0] tidx;
    logic [W:0]     psum;
    logic [W-1:0]   pcarry;
    logic [W:0]     diff;
    logic           ge_calc;

    assign tidx = {2'b00, cmd.i} + {2'b00, cmd.j};

    always_comb begin
        x = '0;
        y = '0;
        case (cmd.op)
            mmm_pkg::OP_PROD: begin
                x = a_reg[cmd.i];
                y = b_reg[cmd.j];
            end
            mmm_pkg::OP_MQ: begin
                x = t_reg[{2'b00, cmd.i}];
                y = neg_inv;
            end
            mmm_pkg::OP_RED: begin
                x = m_reg;
                y = modulus[cmd.j];
            end
            default: ;
        endcase
    end

    // pass 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
    assign mul_x = cmd.part[1] ? x[W-1:HW] : x[HW-1:0];
    assign mul_y = cmd.part[0] ? y[W-1:HW] : y[HW-1:0];
    assign pp    = {{HW{1'b0}}, mul_x} * {{HW{1'b0}}, mul_y};

    always_comb begin
        if (cmd.part == '1) begin
            pp_sh = {pp, {W{1'b0}}};
        end else if (cmd.part[0] ^ cmd.part[1]) begin
            pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
        end else begin
            pp_sh = {{W{1'b0}}, pp};
        end
    end

    assign acc_in = t_reg[tidx];
    assign cin    = cmd.mac_first ? {W{1'b0}} : carry_reg;

    always_comb begin
        if (cmd.part != '0) begin
            base = macc_reg;
        end else if (cmd.op == mmm_pkg::OP_MQ) begin
            base = '0;
        end else begin
            base = {{W{1'b0}}, acc_in} + {{W{1'b0}}, cin};
        end
    end

    assign macc_sum = base + pp_sh;
    assign mac_done = (cmd.part == '1);

    assign pcarry = cmd.prop_first ? carry_reg : {{(W-1){1'b0}}, carry_reg[0]};
    assign psum   = {1'b0, t_reg[cmd.prop_k]} + {1'b0, pcarry};

    // compare t[8..4] with p
    always_comb begin
        ge_calc = 1'b1;
        if (t_reg[8] == '0) begin
            if (t_reg[7] != modulus[3])      ge_calc = t_reg[7] > modulus[3];
            else if (t_reg[6] != modulus[2]) ge_calc = t_reg[6] > modulus[2];
            else if (t_reg[5] != modulus[1]) ge_calc = t_reg[5] > modulus[1];
            else if (t_reg[4] != modulus[0]) ge_calc = t_reg[4] > modulus[0];
        end
    end

    assign diff = {1'b0, t_reg[{2'b01, cmd.sub_j}]} - {1'b0, modulus[cmd.sub_j]}
                - {{W{1'b0}}, (cmd.sub_first ? 1'b0 : borrow_reg)};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg <= a_in;
            b_reg <= b_in;
            for (int n = 0; n < mmm_pkg::T_WORDS; n++) begin
                t_reg[n] <= '0;
            end
        end else if (cmd.op == mmm_pkg::OP_PROD || cmd.op == mmm_pkg::OP_RED) begin
            macc_reg <= macc_sum;
            if (mac_done) begin
                t_reg[tidx] <= macc_sum[W-1:0];
                carry_reg   <= macc_sum[2*W-1:W];
                if (cmd.mac_last && cmd.op == mmm_pkg::OP_PROD) begin
                    t_reg[tidx + 1'b1] <= macc_sum[2*W-1:W];
                end
            end
        end else if (cmd.op == mmm_pkg::OP_MQ) begin
            macc_reg <= macc_sum;
            if (mac_done) begin
                m_reg <= macc_sum[W-1:0];
            end
        end else if (cmd.prop_en) begin
            t_reg[cmd.prop_k] <= psum[W-1:0];
            carry_reg         <= {{(W-1){1'b0}}, psum[W]};
        end
        if (cmd.sub_en) begin
            if (cmd.sub_first) begin
                ge_reg     <= ge_calc;
                borrow_reg <= diff[W];
                res_reg[cmd.sub_j] <= ge_calc ? diff[W-1:0] : t_reg[{2'b01, cmd.sub_j}];
            end else begin
                borrow_reg <= diff[W];
                res_reg[cmd.sub_j] <= ge_reg ? diff[W-1:0] : t_reg[{2'b01, cmd.sub_j}];
            end
        end
    end

    assign r_out = res_reg;

endmodule

// File: hdl/montgomery_modular_multiplier_256.sv
// ----------------------------------------------------------------------------
// montgomery_modular_multiplier_256: 256-bit Montgomery product a*b*2^-256 mod p
// Controller plus word-serial datapath with one 32x32 multiplier.
// ----------------------------------------------------------------------------
//   channel | direction | transaction payload
//   s_      | in        | a_w0..a_w3, b_w0..b_w3
//   m_      | out       | r_w0..r_w3
//   apb     | in        | modulus_w0..w3, neg_inv_word at 8*i
//
// Schedule: every 64x64 multiply-accumulate takes four passes through the one
// 32x32 multiplier. 16 product MACs, then per round 1 m-factor multiply +
// 4 MACs + 5..2 carry ripple steps, then 4 subtraction steps.
// Reset clears the controller and the config registers; the accumulator needs none.
// A result waits in its register while m_ready is low; no new transaction is
// taken until it leaves.
// ----------------------------------------------------------------------------
module montgomery_modular_multiplier_256 #(
    parameter int ADDR_W = mmm_pkg::ADDR_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [63:0]       s_a_w0,
    input  logic [63:0]       s_a_w1,
    input  logic [63:0]       s_a_w2,
    input  logic [63:0]       s_a_w3,
    input  logic [63:0]       s_b_w0,
    input  logic [63:0]       s_b_w1,
    input  logic [63:0]       s_b_w2,
    input  logic [63:0]       s_b_w3,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_r_w0,
    output logic [63:0]       m_r_w1,
    output logic [63:0]       m_r_w2,
    output logic [63:0]       m_r_w3
);

    logic [63:0] modulus_reg [mmm_pkg::NUM_WORDS];
    logic [63:0] neg_inv_reg;
    logic [63:0] a_in [mmm_pkg::NUM_WORDS];
    logic [63:0] b_in [mmm_pkg::NUM_WORDS];
    logic [63:0] r_out [mmm_pkg::NUM_WORDS];
    logic [2:0]  reg_idx;
    logic        busy;
    logic        wr_en;
    mmm_pkg::dp_cmd_t cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    // config writes: registers beyond the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < mmm_pkg::NUM_WORDS; n++) modulus_reg[n] <= '0;
            neg_inv_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                mmm_pkg::REG_MOD_W0:  modulus_reg[0] <= pwdata;
                mmm_pkg::REG_MOD_W1:  modulus_reg[1] <= pwdata;
                mmm_pkg::REG_MOD_W2:  modulus_reg[2] <= pwdata;
                mmm_pkg::REG_MOD_W3:  modulus_reg[3] <= pwdata;
                mmm_pkg::REG_NEG_INV: neg_inv_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mmm_pkg::REG_MOD_W0:  prdata = modulus_reg[0];
            mmm_pkg::REG_MOD_W1:  prdata = modulus_reg[1];
            mmm_pkg::REG_MOD_W2:  prdata = modulus_reg[2];
            mmm_pkg::REG_MOD_W3:  prdata = modulus_reg[3];
            mmm_pkg::REG_NEG_INV: prdata = neg_inv_reg;
            default:              prdata = '0;
        endcase
    end

    assign s_ready = !busy;
    assign a_in = '{s_a_w0, s_a_w1, s_a_w2, s_a_w3};
    assign b_in = '{s_b_w0, s_b_w1, s_b_w2, s_b_w3};

    mmm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid),
        .res_taken (m_ready),
        .busy      (busy),
        .res_valid (m_valid),
        .cmd       (cmd)
    );

    mmm_dp u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .a_in     (a_in),
        .b_in     (b_in),
        .modulus  (modulus_reg),
        .neg_inv  (neg_inv_reg),
        .r_out    (r_out)
    );

    assign m_r_w0 = r_out[0];
    assign m_r_w1 = r_out[1];
    assign m_r_w2 = r_out[2];
    assign m_r_w3 = r_out[3];

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid)
        else $error("result shown right after accept");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> busy)
        else $error("result valid while idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_r_w0) && $stable(m_r_w3))
        else $error("result changed while stalled");

endmodule

// File: tb/sv/montgomery_modular_multiplier_256_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// montgomery_modular_multiplier_256_tb: self-checking bench for the multiplier
// Programs the modulus and reduction factor over APB, streams operand pairs
// through the valid/ready channel and checks every product against a
// word-serial predictor kept in the bench.
// ----------------------------------------------------------------------------
module montgomery_modular_multiplier_256_tb;

    localparam int N_RANDOM    = 1030;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_TICKS = 80;

    typedef struct {
        logic [63:0] a [4];
        logic [63:0] b [4];
        logic        has_exp;
        logic [63:0] r [4];
    } mul_row_t;

    typedef struct {
        logic [63:0] r [4];
    } product_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [mmm_pkg::ADDR_W-1:0] paddr = '0;
    logic [63:0]                pwdata = '0;
    logic [63:0]                prdata;
    logic                       pready;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [63:0]                s_a [4];
    logic [63:0]                s_b [4];
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [63:0]                m_r [4];

    // Bench copy of the configuration registers
    logic [63:0] mod_q [4];
    logic [63:0] ninv_q;

    product_t   pending_products [$];
    int         n_errors = 0;
    int         idle_ticks = 0;
    bit         rx_hold = 1'b0;   // long receiver hold-off request
    bit         no_idle = 1'b0;   // last part of the run: stream at full rate

    initial begin
        for (int i = 0; i < 4; i++) begin
            s_a[i] = '0;
            s_b[i] = '0;
        end
    end

    montgomery_modular_multiplier_256 u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_a_w0  (s_a[0]),
        .s_a_w1  (s_a[1]),
        .s_a_w2  (s_a[2]),
        .s_a_w3  (s_a[3]),
        .s_b_w0  (s_b[0]),
        .s_b_w1  (s_b[1]),
        .s_b_w2  (s_b[2]),
        .s_b_w3  (s_b[3]),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_r_w0  (m_r[0]),
        .m_r_w1  (m_r[1]),
        .m_r_w2  (m_r[2]),
        .m_r_w3  (m_r[3])
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor: 512-bit schoolbook product, four word-wise reduction rounds
    // with the carry out of bit 512 kept, then one conditional subtraction.
    // ------------------------------------------------------------------------
    function automatic product_t mont_product(input logic [63:0] a [4],
                                              input logic [63:0] b [4]);
        logic [63:0]  t [9];
        logic [127:0] acc;
        logic [63:0]  carry;
        logic [63:0]  m;
        logic [256:0] upper;
        logic [256:0] pval;
        logic [256:0] diff;
        product_t     res;
        for (int k = 0; k < 9; k++) t[k] = '0;
        for (int i = 0; i < 4; i++) begin
            carry = '0;
            for (int j = 0; j < 4; j++) begin
                acc = a[i] * b[j] + t[i+j] + carry;
                t[i+j] = acc[63:0];
                carry = acc[127:64];
            end
            t[i+4] = carry;
        end
        for (int i = 0; i < 4; i++) begin
            m = t[i] * ninv_q;
            carry = '0;
            for (int j = 0; j < 4; j++) begin
                acc = m * mod_q[j] + t[i+j] + carry;
                t[i+j] = acc[63:0];
                carry = acc[127:64];
            end
            // ripple the round carry up to word 8
            for (int k = i + 4; k <= 8; k++) begin
                acc = t[k] + carry;
                t[k] = acc[63:0];
                carry = acc[127:64];
            end
        end
        upper = {t[8][0], t[7], t[6], t[5], t[4]};
        pval  = {1'b0, mod_q[3], mod_q[2], mod_q[1], mod_q[0]};
        // any set bit above 256 always counts as not below p
        if (t[8] != 0 || upper >= pval) diff = upper - pval;
        else diff = upper;
        for (int j = 0; j < 4; j++) res.r[j] = diff[64*j +: 64];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // APB writes: setup cycle, then access cycle; pready is always high.
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        @(negedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= mmm_pkg::ADDR_W'(8 * idx);
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < mmm_pkg::REG_NEG_INV) mod_q[idx[1:0]] = value;
        else if (idx == mmm_pkg::REG_NEG_INV) ninv_q = value;
    endtask

    // Compute -p^-1 mod 2^64 by Newton iteration (doubling precision each step)
    function automatic logic [63:0] neg_inverse(input logic [63:0] p0);
        logic [63:0] x;
        x = p0;
        for (int i = 0; i < 6; i++) x = x * (64'd2 - p0 * x);
        return -x;
    endfunction

    task automatic load_modulus(input logic [63:0] p [4], input logic [63:0] ninv);
        apb_write(mmm_pkg::REG_MOD_W0, p[0]);
        apb_write(mmm_pkg::REG_MOD_W1, p[1]);
        apb_write(mmm_pkg::REG_MOD_W2, p[2]);
        apb_write(mmm_pkg::REG_MOD_W3, p[3]);
        apb_write(mmm_pkg::REG_NEG_INV, ninv);
    endtask

    // Wait for the block to go idle: all products back, then the pipeline drains.
    task automatic wait_drained();
        while (pending_products.size() != 0) @(posedge aclk);
        repeat (DRAIN_TICKS) @(posedge aclk);
    endtask

    // Offer one operand pair and hold it until the transaction is taken.
    task automatic send_pair(input logic [63:0] a [4], input logic [63:0] b [4],
                             input bit expect_given, input logic [63:0] r [4]);
        product_t pr;
        if (!no_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        @(negedge aclk);
        for (int i = 0; i < 4; i++) begin
            s_a[i] <= a[i];
            s_b[i] <= b[i];
        end
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pr = mont_product(a, b);
        if (expect_given) begin
            for (int i = 0; i < 4; i++)
                if (pr.r[i] !== r[i]) report_mismatch("predictor vs table", pr.r[i], r[i]);
        end
        pending_products.push_back(pr);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                rx_hold = 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Checker and watchdog: sample at the rising edge.
    always @(posedge aclk) begin
        product_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_ticks <= 0;
            else idle_ticks <= idle_ticks + 1;
            if (m_valid && m_ready) begin
                if (pending_products.size() == 0) begin
                    $display("[%0t] unexpected product transaction", $time);
                    n_errors++;
                end else begin
                    want = pending_products.pop_front();
                    if (m_r[0] !== want.r[0]) report_mismatch("r_w0", m_r[0], want.r[0]);
                    if (m_r[1] !== want.r[1]) report_mismatch("r_w1", m_r[1], want.r[1]);
                    if (m_r[2] !== want.r[2]) report_mismatch("r_w2", m_r[2], want.r[2]);
                    if (m_r[3] !== want.r[3]) report_mismatch("r_w3", m_r[3], want.r[3]);
                end
            end
        end
    end

    initial begin
        wait (idle_ticks >= WDOG_LIMIT);
        $display("watchdog expired with %0d products outstanding",
                 pending_products.size());
        $display("montgomery_modular_multiplier_256_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        mul_row_t    rows [$];
        mul_row_t    row;
        logic [63:0] p [4];
        logic [63:0] a [4];
        logic [63:0] b [4];
        logic [63:0] z [4];
        int          n_sent;

        for (int i = 0; i < 4; i++) begin
            mod_q[i] = '0;
            z[i] = '0;
        end
        ninv_q = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table, registers still at reset (p = 0, factor 0): the
        // reduction adds nothing and the product's upper half comes back.
        row.has_exp = 1'b1;
        for (int i = 0; i < 4; i++) begin
            row.a[i] = '0; row.b[i] = '0; row.r[i] = '0;
        end
        rows.push_back(row);                       // zero times zero
        for (int i = 0; i < 4; i++) begin
            row.a[i] = '1; row.b[i] = '1;
        end
        // (2^256-1)^2 upper half = 2^256 - 2
        row.r[0] = 64'hFFFF_FFFF_FFFF_FFFE;
        for (int i = 1; i < 4; i++) row.r[i] = '1;
        rows.push_back(row);
        for (int i = 0; i < 4; i++) begin
            row.a[i] = '0; row.b[i] = '0; row.r[i] = '0;
        end
        row.a[3] = 64'h8000_0000_0000_0000;        // 2^255 * 2 = 2^256 -> 1
        row.b[0] = 64'd2;
        row.r[0] = 64'd1;
        rows.push_back(row);
        foreach (rows[k]) send_pair(rows[k].a, rows[k].b, rows[k].has_exp, rows[k].r);
        wait_drained();

        // Odd modulus p = 2^256 - 189 with the proper factor; operands at and
        // above p, one and the biggest value exercise the one-subtraction case.
        p[0] = 64'hFFFF_FFFF_FFFF_FF43; p[1] = '1; p[2] = '1; p[3] = '1;
        load_modulus(p, neg_inverse(p[0]));
        rows.delete();
        row.has_exp = 1'b0;
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 4; i++) begin
                row.a[i] = (k[0]) ? p[i] : '1;
                row.b[i] = (k[1]) ? '1 : ((i == 0) ? 64'd1 : 64'd0);
            end
            if (k[2]) row.a[0] = '0;
            rows.push_back(row);
        end
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 4; i++) begin
                row.a[i] = rand64();
                row.b[i] = rand64();
            end
            rows.push_back(row);
        end
        foreach (rows[k]) send_pair(rows[k].a, rows[k].b, rows[k].has_exp, rows[k].r);
        wait_drained();

        // Random phases: each programs a new setting, including an even
        // modulus, a wrong factor and the all-ones extreme.
        n_sent = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    for (int i = 0; i < 4; i++) p[i] = '1;
                    load_modulus(p, neg_inverse(p[0]));
                end
                3: begin
                    for (int i = 0; i < 4; i++) p[i] = {$urandom, $urandom};
                    p[0][0] = 1'b0;
                    load_modulus(p, {$urandom, $urandom});
                end
                5: begin
                    for (int i = 0; i < 4; i++) p[i] = '0;
                    p[0] = 64'd1;
                    load_modulus(p, '1);
                end
                default: begin
                    for (int i = 0; i < 4; i++) p[i] = {$urandom, $urandom};
                    p[3][63] = 1'b1;
                    p[0][0]  = 1'b1;
                    load_modulus(p, neg_inverse(p[0]));
                end
            endcase
            if (ph == 7) no_idle = 1'b1;
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                if (ph == 2 && n == 10) rx_hold = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    // mostly operands reduced below a large p, some raw words
                    a[i] = rand64();
                    b[i] = rand64();
                end
                if ($urandom_range(0, 3) != 0) begin
                    a[3] = a[3] >> 1;
                    b[3] = b[3] >> 1;
                end
                send_pair(a, b, 1'b0, z);
                n_sent++;
                // sender pause until every product is back
                if (ph == 4 && n == 40)
                    while (pending_products.size() != 0) @(posedge aclk);
            end
            wait_drained();
        end

        wait_drained();
        if (n_errors == 0) begin
            $display("montgomery_modular_multiplier_256_tb passed");
        end else begin
            $display("montgomery_modular_multiplier_256_tb failed");
        end
        $finish;
    end

endmodule

// File: montgomery_modular_multiplier_256.f
hdl/mmm_pkg.sv
hdl/mmm_ctrl.sv
hdl/mmm_dp.sv
hdl/montgomery_modular_multiplier_256.sv
tb/sv/montgomery_modular_multiplier_256_tb.sv
